// ===== design/pic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

	localparam int DATA_W  = 32;
	localparam int GAIN_W  = 32;
	localparam int PER_W   = 31;
	localparam int MA_W    = DATA_W + 1;
	localparam int MB_W    = DATA_W;
	localparam int PROD_W  = MA_W + 1 + MB_W;
	localparam int CNT_W   = $clog2(MB_W);
	localparam int Q_SHIFT = 16;
	localparam int ADDR_W  = 5;
	localparam int IDX_W   = 3;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [MA_W-1:0]   mul_a_t;
	typedef logic signed [MB_W-1:0]   mul_b_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_PERIOD     = 3'd2,
		REG_INTEG_MAX  = 3'd3,
		REG_INTEG_MIN  = 3'd4,
		REG_DRIVE_MAX  = 3'd5,
		REG_DRIVE_MIN  = 3'd6,
		REG_NONE       = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MUL1,
		ST_MUL2,
		ST_INTEG,
		ST_DRIVE
	} state_t;

	typedef struct packed {
		logic start;
		logic done;
	} mul_ctl_t;

	localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	function automatic data_t sat33(input logic signed [DATA_W:0] x);
		data_t r;
		if (x[DATA_W] != x[DATA_W-1]) begin
			r = x[DATA_W] ? DATA_MIN : DATA_MAX;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic data_t sat_shr(input prod_t p, input int unsigned s);
		prod_t sh;
		data_t r;
		sh = p >>> s;
		if (sh > prod_t'(DATA_MAX)) begin
			r = DATA_MAX;
		end else if (sh < prod_t'(DATA_MIN)) begin
			r = DATA_MIN;
		end else begin
			r = sh[DATA_W-1:0];
		end
		return r;
	endfunction

	function automatic data_t clamp(input data_t x, input data_t hi, input data_t lo);
		data_t r;
		if (x > hi) begin
			r = hi;
		end else if (x < lo) begin
			r = lo;
		end else begin
			r = x;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/pic_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pic_in_if;
	import pic_pkg::*;

	logic  valid;
	logic  ready;
	data_t target;
	data_t measured;

	modport source (output valid, output target, output measured, input ready);
	modport sink (input valid, input target, input measured, output ready);
endinterface

interface pic_out_if;
	import pic_pkg::*;

	logic  valid;
	logic  ready;
	data_t drive;

	modport source (output valid, output drive, input ready);
	modport sink (input valid, input drive, output ready);
endinterface

`default_nettype wire

// ===== design/pic_smul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pic_smul (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire pic_pkg::mul_a_t a,
	input  wire pic_pkg::mul_b_t b,
	input  wire logic            start,
	output pic_pkg::mul_ctl_t    stat,
	output pic_pkg::prod_t       prod
);
	import pic_pkg::*;

	logic signed [MA_W:0]   hi_q;
	logic [MB_W-1:0]        lo_q;
	mul_a_t                 a_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic                   last;
	logic signed [MA_W+1:0] addend;
	logic signed [MA_W+1:0] t;

	assign last = (cnt_q == CNT_W'(MB_W - 1));

	always_comb begin
		if (!lo_q[0]) begin
			addend = '0;
		end else if (last) begin
			addend = -(MA_W+2)'(a_q);
		end else begin
			addend = (MA_W+2)'(a_q);
		end
		t = (MA_W+2)'(hi_q) + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end else if (busy_q) begin
			hi_q <= t[MA_W+1:1];
			lo_q <= {t[0], lo_q[MB_W-1:1]};
		end
	end

	assign prod = {hi_q, lo_q};

	always_comb begin
		stat.start = start;
		stat.done  = done_q;
	end

endmodule

`default_nettype wire

// ===== design/pi_controller_clamped.sv =====
// PI controller, Q16.16, trapezoidal integrator with clamped integrator and output.
// A new item is accepted only in the idle state, after the previous result is registered.
// Most of the work is done by two bit-serial 33x32 multipliers, 32 steps each, run in two rounds.
// A finished result waits in an output register while the next item is accepted.
// Reset (arst_n low, asynchronous) clears control, settings, integrator, previous error to 0.
`timescale 1ns / 1ps
`default_nettype none

module pi_controller_clamped (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	pic_in_if.sink                       sample,
	pic_out_if.source                    result,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [pic_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]             pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import pic_pkg::*;

	state_t st_q, st_d;

	data_t             prop_gain_q;
	data_t             integ_gain_q;
	logic [PER_W-1:0]  period_q;
	data_t             integ_max_q;
	data_t             integ_min_q;
	data_t             drive_max_q;
	data_t             drive_min_q;

	data_t             integ_q;
	data_t             last_err_q;
	data_t             err_q;
	logic signed [DATA_W:0] sum_q;
	data_t             prop_q;
	data_t             inc_q;
	data_t             drive_q;
	logic              out_valid_q;

	reg_idx_t          widx;
	logic              wr_en;
	logic              out_free;
	logic              in_take;
	logic              start_p;
	logic              start_g;
	mul_a_t            a_g;
	mul_b_t            b_g;
	data_t             g;
	prod_t             prod_p;
	prod_t             prod_g;
	mul_ctl_t          stat_p;
	mul_ctl_t          stat_g;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;

	always_comb begin
		unique case (widx)
			REG_PROP_GAIN:  prdata = prop_gain_q;
			REG_INTEG_GAIN: prdata = integ_gain_q;
			REG_PERIOD:     prdata = {1'b0, period_q};
			REG_INTEG_MAX:  prdata = integ_max_q;
			REG_INTEG_MIN:  prdata = integ_min_q;
			REG_DRIVE_MAX:  prdata = drive_max_q;
			REG_DRIVE_MIN:  prdata = drive_min_q;
			default:        prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || result.ready;
	assign g        = sat_shr(prod_g, Q_SHIFT);

	always_comb begin
		st_d         = st_q;
		sample.ready = 1'b0;
		start_p      = 1'b0;
		start_g      = 1'b0;
		a_g          = MA_W'(integ_gain_q);
		b_g          = MB_W'({1'b0, period_q});
		unique case (st_q)
			ST_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) begin
					st_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				start_p = 1'b1;
				start_g = 1'b1;
				st_d    = ST_MUL1;
			end
			ST_MUL1: begin
				a_g = sum_q;
				b_g = g;
				if (stat_g.done) begin
					start_g = 1'b1;
					st_d    = ST_MUL2;
				end
			end
			ST_MUL2: begin
				if (stat_g.done) begin
					st_d = ST_INTEG;
				end
			end
			ST_INTEG: begin
				st_d = ST_DRIVE;
			end
			ST_DRIVE: begin
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	assign in_take = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	pic_smul u_mul_p (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (MA_W'(prop_gain_q)),
		.b      (err_q),
		.start  (start_p),
		.stat   (stat_p),
		.prod   (prod_p)
	);

	pic_smul u_mul_g (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (a_g),
		.b      (b_g),
		.start  (start_g),
		.stat   (stat_g),
		.prod   (prod_g)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= '0;
			integ_gain_q <= '0;
			period_q     <= '0;
			integ_max_q  <= '0;
			integ_min_q  <= '0;
			drive_max_q  <= '0;
			drive_min_q  <= '0;
			integ_q      <= '0;
			last_err_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (widx)
					REG_PROP_GAIN:  prop_gain_q  <= pwdata;
					REG_INTEG_GAIN: integ_gain_q <= pwdata;
					REG_PERIOD:     period_q     <= pwdata[PER_W-1:0];
					REG_INTEG_MAX:  integ_max_q  <= pwdata;
					REG_INTEG_MIN:  integ_min_q  <= pwdata;
					REG_DRIVE_MAX:  drive_max_q  <= pwdata;
					REG_DRIVE_MIN:  drive_min_q  <= pwdata;
					default: begin
					end
				endcase
			end
			if (st_q == ST_LOAD) begin
				last_err_q <= err_q;
			end
			if (st_q == ST_INTEG) begin
				integ_q <= clamp(sat33((DATA_W+1)'(integ_q) + (DATA_W+1)'(inc_q)),
					integ_max_q, integ_min_q);
			end
			if (st_q == ST_DRIVE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			err_q <= sat33((DATA_W+1)'(sample.target) - (DATA_W+1)'(sample.measured));
		end
		if (st_q == ST_LOAD) begin
			sum_q <= (DATA_W+1)'(err_q) + (DATA_W+1)'(last_err_q);
		end
		if (st_q == ST_MUL1 && stat_p.done) begin
			prop_q <= sat_shr(prod_p, Q_SHIFT);
		end
		if (st_q == ST_MUL2 && stat_g.done) begin
			inc_q <= sat_shr(prod_g, Q_SHIFT + 1);
		end
		if (st_q == ST_DRIVE && out_free) begin
			drive_q <= clamp(sat33((DATA_W+1)'(prop_q) + (DATA_W+1)'(integ_q)),
				drive_max_q, drive_min_q);
		end
	end

	assign result.valid = out_valid_q;
	assign result.drive = drive_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import pic_pkg::*;

	typedef logic signed [95:0] wide_t;
	typedef struct packed {
		data_t tgt;
		data_t meas;
	} setpoint_pair_t;

	localparam wide_t WIDE_MAX = 96'sh7FFF_FFFF;
	localparam wide_t WIDE_MIN = -WIDE_MAX - 1;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	pic_in_if  smp();
	pic_out_if res();

	pi_controller_clamped dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (smp),
		.result  (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	data_t       kp_q, ki_q, imax_q, imin_q, dmax_q, dmin_q;
	logic [30:0] period_q;
	data_t       integ_q, prev_err_q;

	setpoint_pair_t pending_q[$];
	data_t          drive_q[$];

	bit presenting;
	bit steady;
	int gap_left;
	int stall_left;
	int items_sent;
	int drives_checked;
	int settings_used;
	int errors;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic wide_t clip_word(input wide_t x);
		if (x > WIDE_MAX) begin
			return WIDE_MAX;
		end
		if (x < WIDE_MIN) begin
			return WIDE_MIN;
		end
		return x;
	endfunction

	function automatic data_t limit(input data_t x, input data_t hi, input data_t lo);
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	function automatic data_t step_loop(input data_t tgt, input data_t meas);
		wide_t t_w, m_w, kp_w, ki_w, per_w, acc_w, prev_w;
		wide_t err, prop, g, sum, inc;
		data_t drv;
		t_w = tgt;
		m_w = meas;
		kp_w = kp_q;
		ki_w = ki_q;
		per_w = {65'd0, period_q};
		acc_w = integ_q;
		prev_w = prev_err_q;
		err = clip_word(t_w - m_w);
		prop = clip_word((kp_w * err) >>> Q_SHIFT);
		g = clip_word((ki_w * per_w) >>> Q_SHIFT);
		sum = err + prev_w;
		inc = clip_word((g * sum) >>> (Q_SHIFT + 1));
		integ_q = limit(data_t'(clip_word(acc_w + inc)), imax_q, imin_q);
		acc_w = integ_q;
		drv = limit(data_t'(clip_word(prop + acc_w)), dmax_q, dmin_q);
		prev_err_q = data_t'(err);
		return drv;
	endfunction

	function automatic int pick_delay();
		int r;
		if (steady) begin
			return 0;
		end
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(3, 1);
		end
		if (r < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(90, 30);
	endfunction

	function automatic data_t rand_signed(input int bits);
		data_t v;
		v = $urandom;
		return v >>> (31 - bits);
	endfunction

	function automatic data_t corner_value();
		case ($urandom_range(4))
			0: return DATA_MIN;
			1: return DATA_MAX;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	always @(posedge clk) begin
		setpoint_pair_t nxt;
		if (presenting && smp.ready === 1'b1) begin
			drive_q.push_back(step_loop(smp.target, smp.measured));
			presenting = 1'b0;
			gap_left = pick_delay();
		end
		if (!presenting) begin
			if (gap_left > 0) begin
				gap_left--;
				smp.valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				nxt = pending_q.pop_front();
				smp.valid <= 1'b1;
				smp.target <= nxt.tgt;
				smp.measured <= nxt.meas;
				presenting = 1'b1;
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		data_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (drive_q.size() == 0) begin
				$error("drive: no item pending, got %0d", res.drive);
				errors++;
			end else begin
				want = drive_q.pop_front();
				drives_checked++;
				if (res.drive !== want) begin
					$error("drive: expected %0d, actual %0d", want, res.drive);
					errors++;
				end
			end
		end
		if (!steady && stall_left == 0) begin
			stall_left = pick_delay();
		end
		if (steady || stall_left == 0) begin
			res.ready <= 1'b1;
		end else begin
			res.ready <= 1'b0;
			stall_left--;
		end
	end

	task automatic send_sample(input data_t tgt, input data_t meas);
		pending_q.push_back('{tgt: tgt, meas: meas});
		items_sent++;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (pending_q.size() != 0 || presenting || drive_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PROP_GAIN:  kp_q = value;
			REG_INTEG_GAIN: ki_q = value;
			REG_PERIOD:     period_q = value[30:0];
			REG_INTEG_MAX:  imax_q = value;
			REG_INTEG_MIN:  imin_q = value;
			REG_DRIVE_MAX:  dmax_q = value;
			REG_DRIVE_MIN:  dmin_q = value;
			default: ;
		endcase
	endtask

	task automatic apply_setting(input data_t kp, input data_t ki, input logic [31:0] per,
			input data_t imax, input data_t imin, input data_t dmax, input data_t dmin);
		write_reg(REG_PROP_GAIN, kp);
		write_reg(REG_INTEG_GAIN, ki);
		write_reg(REG_PERIOD, per);
		write_reg(REG_INTEG_MAX, imax);
		write_reg(REG_INTEG_MIN, imin);
		write_reg(REG_DRIVE_MAX, dmax);
		write_reg(REG_DRIVE_MIN, dmin);
		settings_used++;
	endtask

	task automatic test_reset_defaults();
		send_sample(32'sh0123_4567, -32'sh0765_4321);
		send_sample(DATA_MAX, DATA_MIN);
		wait_idle();
	endtask

	task automatic test_field_extremes();
		apply_setting(32'sh0001_0000, 32'sh0001_0000, 32'h0001_0000,
			DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
		send_sample(DATA_MAX, DATA_MIN);
		send_sample(DATA_MAX, DATA_MIN);
		send_sample(DATA_MIN, DATA_MAX);
		send_sample(DATA_MIN, DATA_MAX);
		send_sample(0, 0);
		send_sample(-1, 0);
		send_sample(1, -1);
		send_sample(DATA_MAX, DATA_MAX);
		send_sample(32'sh0001_0000, 0);
		wait_idle();
		// bit 31 of the period must be dropped
		apply_setting(DATA_MAX, DATA_MAX, 32'hFFFF_FFFF,
			DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
		send_sample(DATA_MAX, DATA_MIN);
		send_sample(1, 0);
		send_sample(-1, 0);
		wait_idle();
	endtask

	task automatic test_crossed_limits();
		apply_setting(32'sh0000_8000, 32'sh0001_0000, 32'h0000_4000,
			-32'sh0005_0000, 32'sh0005_0000, -32'sh0003_0000, 32'sh0003_0000);
		send_sample(0, 0);
		send_sample(32'sh000A_0000, 0);
		send_sample(-32'sh000A_0000, 0);
		send_sample(0, 32'sh0001_0000);
		wait_idle();
	endtask

	task automatic test_integrator_overflow();
		apply_setting(0, DATA_MIN, 32'h0001_0000, DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
		send_sample(DATA_MIN, DATA_MAX);
		send_sample(DATA_MIN, DATA_MAX);
		send_sample(DATA_MIN, DATA_MAX);
		wait_idle();
	endtask

	task automatic test_unmapped_register();
		apply_setting(32'sh0002_0000, 32'sh0000_8000, 32'h0000_1000,
			32'sh0010_0000, -32'sh0010_0000, 32'sh0020_0000, -32'sh0020_0000);
		write_reg(REG_NONE, 32'hFFFF_FFFF);
		send_sample(32'sh0004_0000, 32'sh0001_0000);
		send_sample(-32'sh0004_0000, 32'sh0001_0000);
		wait_idle();
	endtask

	task automatic random_phase(input int style, input int count);
		data_t a, b, c, d;
		data_t tgt, meas;
		logic [31:0] per;
		int r;
		a = rand_signed($urandom_range(28, 16));
		b = rand_signed($urandom_range(28, 16));
		c = rand_signed($urandom_range(30, 16));
		d = rand_signed($urandom_range(30, 16));
		per = $urandom_range(32'h0001_0000, 64);
		case (style)
			0, 4: apply_setting(rand_signed(18), rand_signed(18), per,
				(a > b) ? a : b, (a > b) ? b : a, (c > d) ? c : d, (c > d) ? d : c);
			1: apply_setting($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
			2: apply_setting(DATA_MAX, DATA_MAX, 32'h7FFF_FFFF,
				DATA_MAX, DATA_MIN, DATA_MAX, DATA_MIN);
			3: apply_setting(DATA_MIN, DATA_MIN, 32'h0000_0001,
				DATA_MIN, DATA_MAX, DATA_MIN, DATA_MAX);
			default: apply_setting(rand_signed(20), rand_signed(20),
				$urandom_range(1) ? 32'h0 : per,
				rand_signed(16) & DATA_MAX, -(rand_signed(16) & DATA_MAX),
				rand_signed(17) & DATA_MAX, -(rand_signed(17) & DATA_MAX));
		endcase
		steady = (style == 4);
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 12) begin
				tgt = corner_value();
				meas = corner_value();
			end else if (r < 35) begin
				tgt = $urandom;
				meas = $urandom;
			end else begin
				tgt = rand_signed($urandom_range(24, 8));
				meas = tgt + rand_signed($urandom_range(18, 2));
			end
			send_sample(tgt, meas);
		end
		wait_idle();
		steady = 1'b0;
	endtask

	task automatic test_random_settings();
		for (int style = 0; style < 6; style++) begin
			random_phase(style, 105);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		smp.valid = 1'b0;
		smp.target = '0;
		smp.measured = '0;
		res.ready = 1'b0;
		kp_q = 0;
		ki_q = 0;
		period_q = '0;
		imax_q = 0;
		imin_q = 0;
		dmax_q = 0;
		dmin_q = 0;
		integ_q = 0;
		prev_err_q = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_crossed_limits();
		test_integrator_overflow();
		test_unmapped_register();
		test_random_settings();
		wait_idle();
		repeat (80) @(posedge clk);
		$display("%0d setpoint/measurement items sent over %0d register settings",
			items_sent, settings_used);
		$display("%0d drive results checked, %0d mismatches", drives_checked, errors);
		if (errors == 0 && drive_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
